// ----- rtl/tgms_pkg.sv -----
`default_nettype none
package tgms_pkg;

    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 12;
    localparam int COORD_W    = 8;
    localparam int T_W        = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int GRID_X_DEF = 16;
    localparam int GRID_Y_DEF = 16;
    localparam int GRID_Z_DEF = 16;
    localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_ORIGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_INV     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_INV     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_INV     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 3'd7;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Axis weight selectors for the blend schedule
    localparam logic [1:0] TSEL_X = 2'd0;
    localparam logic [1:0] TSEL_Y = 2'd1;
    localparam logic [1:0] TSEL_Z = 2'd2;

    // Work handed from the mapping front to the sampling back
    typedef struct packed {
        logic                           is_load;
        logic [ADDR_W-1:0]              cell_index;
        logic [DATA_W-1:0]              cell_value;
        logic                           outside;
        logic [2:0][COORD_W-1:0]        lo;
        logic [2:0][COORD_W-1:0]        hi;
        logic [2:0][T_W-1:0]            t;
    } tgms_job_t;

    // One step of the blend schedule: w[a] = lerp(w[a], w[b], t[tsel])
    typedef struct packed {
        logic [2:0] a;
        logic [2:0] b;
        logic [1:0] tsel;
    } tgms_step_t;

    function automatic tgms_step_t blend_step(input logic [2:0] s);
        tgms_step_t r;
        case (s)
            3'd0:    r = '{a: 3'd0, b: 3'd1, tsel: TSEL_X};
            3'd1:    r = '{a: 3'd2, b: 3'd3, tsel: TSEL_X};
            3'd2:    r = '{a: 3'd0, b: 3'd2, tsel: TSEL_Y};
            3'd3:    r = '{a: 3'd4, b: 3'd5, tsel: TSEL_X};
            3'd4:    r = '{a: 3'd6, b: 3'd7, tsel: TSEL_X};
            3'd5:    r = '{a: 3'd4, b: 3'd6, tsel: TSEL_Y};
            3'd6:    r = '{a: 3'd0, b: 3'd4, tsel: TSEL_Z};
            default: r = '{a: 3'd0, b: 3'd0, tsel: TSEL_X};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tgms_front.sv -----
`default_nettype none
module tgms_front #(
    parameter int GRID_X = tgms_pkg::GRID_X_DEF,
    parameter int GRID_Y = tgms_pkg::GRID_Y_DEF,
    parameter int GRID_Z = tgms_pkg::GRID_Z_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            in_type,
    input  wire logic [tgms_pkg::ADDR_W-1:0]     in_index,
    input  wire logic [tgms_pkg::DATA_W-1:0]     in_value,
    input  wire logic [2:0][tgms_pkg::DATA_W-1:0] in_q,
    input  wire logic [2:0][tgms_pkg::DATA_W-1:0] org,
    input  wire logic [2:0][tgms_pkg::DATA_W-1:0] inv,
    output logic                                 push,
    input  wire logic                            full,
    output tgms_pkg::tgms_job_t                  job
);
    localparam int DW = tgms_pkg::DATA_W;
    localparam int CW = tgms_pkg::COORD_W;
    localparam logic [1:0] NAX = (GRID_Z > 1) ? 2'd3 : 2'd2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAP  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [1:0]              cnt_reg;
    logic                    type_reg;
    logic [tgms_pkg::ADDR_W-1:0] index_reg;
    logic [DW-1:0]           value_reg;
    logic [2:0][DW-1:0]      q_reg;
    logic [2*DW-1:0]         prod_reg;
    logic                    neg_reg, zinv_reg;
    logic [1:0]              ax_reg;
    logic                    out_reg;
    logic [2:0][CW-1:0]      lo_reg, hi_reg;
    logic [2:0][tgms_pkg::T_W-1:0] t_reg;

    logic [1:0]              axs;
    logic [DW:0]             diff;
    logic [DW-1:0]           nmax;
    logic [DW-1:0]           ip;
    logic [CW-1:0]           lo_c, hi_c;
    logic                    out_c;

    assign in_ready = (state_reg == ST_IDLE);
    assign push     = (state_reg == ST_PUSH) && !full;

    // Offset from the origin for the axis being mapped
    assign axs  = cnt_reg;
    assign diff = {q_reg[axs][DW-1], q_reg[axs]} - {org[axs][DW-1], org[axs]};

    // Range check of the registered product for the previous axis
    always_comb begin
        nmax = DW'((ax_reg == 2'd0) ? GRID_X - 1 : (ax_reg == 2'd1) ? GRID_Y - 1 : GRID_Z - 1);
        ip   = prod_reg[2*DW-1:DW];
        lo_c = '0;
        hi_c = '0;
        out_c = 1'b0;
        if (!zinv_reg) begin
            if (neg_reg || ip > nmax || (ip == nmax && prod_reg[DW-1:0] != '0)) begin
                out_c = 1'b1;
            end else begin
                lo_c = ip[CW-1:0];
                hi_c = (ip < nmax) ? CW'(ip + 1'b1) : nmax[CW-1:0];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = (in_type == tgms_pkg::REQ_QUERY) ? ST_MAP : ST_PUSH;
            ST_MAP:  if (cnt_reg == NAX) state_next = ST_PUSH;
            ST_PUSH: if (!full) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the beat, then map one axis a cycle through the shared multiplier
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_valid) begin
            type_reg  <= in_type;
            index_reg <= in_index;
            value_reg <= in_value;
            q_reg     <= in_q;
            cnt_reg   <= 2'd0;
            out_reg   <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            t_reg     <= '0;
        end else if (state_reg == ST_MAP) begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg != NAX) begin
                prod_reg <= diff[DW-1:0] * inv[axs];
                neg_reg  <= diff[DW];
                zinv_reg <= (inv[axs] == '0);
                ax_reg   <= axs;
            end
            if (cnt_reg != 2'd0) begin
                lo_reg[ax_reg] <= lo_c;
                hi_reg[ax_reg] <= hi_c;
                t_reg[ax_reg]  <= out_c ? '0 : prod_reg[DW-1:DW-tgms_pkg::T_W];
                out_reg        <= out_reg | out_c;
            end
        end
    end

    always_comb begin
        job.is_load    = (type_reg == tgms_pkg::REQ_LOAD);
        job.cell_index = index_reg;
        job.cell_value = value_reg;
        job.outside    = out_reg;
        job.lo         = lo_reg;
        job.hi         = hi_reg;
        job.t          = t_reg;
    end
endmodule
`default_nettype wire

// ----- rtl/tgms_queue.sv -----
`default_nettype none
module tgms_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire tgms_pkg::tgms_job_t wr_job,
    output logic                     full,
    input  wire logic                pop,
    output logic                     nonempty,
    output tgms_pkg::tgms_job_t      rd_job
);
    tgms_pkg::tgms_job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign rd_job   = mem_reg[rp_reg];

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_job;
    end
endmodule
`default_nettype wire

// ----- rtl/tgms_back.sv -----
`default_nettype none
module tgms_back #(
    parameter int GRID_X = tgms_pkg::GRID_X_DEF,
    parameter int GRID_Y = tgms_pkg::GRID_Y_DEF,
    parameter int GRID_Z = tgms_pkg::GRID_Z_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_nonempty,
    input  wire tgms_pkg::tgms_job_t         q_job,
    output logic                             pop,
    input  wire logic [tgms_pkg::DATA_W-1:0] threshold,
    input  wire logic                        invert,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tgms_pkg::DATA_W-1:0]      out_phi,
    output logic                             out_flag
);
    localparam int DW = tgms_pkg::DATA_W;
    localparam int AW = tgms_pkg::ADDR_W;
    localparam int TW = tgms_pkg::T_W;
    localparam logic [3:0] NC = (GRID_Z > 1) ? 4'd8 : 4'd4;
    localparam logic [2:0] NB = (GRID_Z > 1) ? 3'd7 : 3'd3;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_BLEND = 2'd2;
    localparam logic [1:0] ST_PHI   = 2'd3;

    logic [DW-1:0] grid_mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    logic [1:0]             state_reg;
    logic [3:0]             cnt_reg;
    tgms_pkg::tgms_job_t    job_reg;
    logic [7:0][DW-1:0]     w_reg;
    logic                   out_valid_reg;
    logic [DW-1:0]          phi_reg;
    logic                   flag_reg;

    logic [2:0]             c;
    logic [31:0]            addr_full;
    tgms_pkg::tgms_step_t   st;
    logic [TW-1:0]          tw;
    logic signed [DW:0]     bdiff;
    logic signed [DW+TW+1:0] bprod;
    logic signed [DW+TW+1:0] bq;
    logic [DW-1:0]          bres;
    logic signed [DW:0]     pdiff;
    logic [DW-1:0]          psat;

    assign out_valid = out_valid_reg;
    assign out_phi   = phi_reg;
    assign out_flag  = flag_reg;
    assign pop       = (state_reg == ST_IDLE) && q_nonempty && !out_valid_reg;

    // Corner address: bit 0 picks x, bit 1 y, bit 2 z
    assign c = cnt_reg[2:0];
    assign addr_full = ((32'(c[2] ? job_reg.hi[2] : job_reg.lo[2]) * 32'(GRID_Y)
                       + 32'(c[1] ? job_reg.hi[1] : job_reg.lo[1])) * 32'(GRID_X)
                       + 32'(c[0] ? job_reg.hi[0] : job_reg.lo[0]));

    // One blend: a + floor((t * (b - a) + half) / 65536)
    always_comb begin
        st    = tgms_pkg::blend_step(cnt_reg[2:0]);
        tw    = job_reg.t[st.tsel];
        bdiff = $signed({w_reg[st.b][DW-1], w_reg[st.b]}) - $signed({w_reg[st.a][DW-1], w_reg[st.a]});
        bprod = $signed({1'b0, tw}) * bdiff;
        bq    = (bprod + $signed((DW+TW+2)'(32768))) >>> TW;
        bres  = w_reg[st.a] + bq[DW-1:0];
    end

    // Level difference with saturation
    always_comb begin
        if (invert == 1'b1) begin
            pdiff = $signed({threshold[DW-1], threshold}) - $signed({w_reg[0][DW-1], w_reg[0]});
        end else begin
            pdiff = $signed({w_reg[0][DW-1], w_reg[0]}) - $signed({threshold[DW-1], threshold});
        end
        if (pdiff[DW] != pdiff[DW-1]) begin
            psat = pdiff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            psat = pdiff[DW-1:0];
        end
    end

    // Grid store: one write or one read per cycle
    always_ff @(posedge aclk) begin
        if (pop && q_job.is_load) begin
            grid_mem[q_job.cell_index] <= q_job.cell_value;
        end else if (state_reg == ST_READ && cnt_reg < NC) begin
            rd_data_reg <= grid_mem[addr_full[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (pop && !q_job.is_load) begin
                        if (q_job.outside) begin
                            out_valid_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_READ;
                            cnt_reg   <= '0;
                        end
                    end
                end
                ST_READ: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == NC) begin
                        state_reg <= ST_BLEND;
                        cnt_reg   <= '0;
                    end
                end
                ST_BLEND: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg[2:0] == NB - 3'd1) state_reg <= ST_PHI;
                end
                ST_PHI: begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Payload: job, corner values, blend results, result beat
    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg  <= q_job;
            phi_reg  <= tgms_pkg::ONE_Q16;
            flag_reg <= 1'b1;
        end
        if (state_reg == ST_READ && cnt_reg != 4'd0) begin
            w_reg[cnt_reg[2:0] - 3'd1] <= rd_data_reg;
        end
        if (state_reg == ST_BLEND) begin
            w_reg[st.a] <= bres;
        end
        if (state_reg == ST_PHI) begin
            phi_reg  <= psat;
            flag_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/trilinear_grid_mask_sampler.sv -----
`default_nettype none
// Trilinear mask sampler over a GRID_X x GRID_Y x GRID_Z store of signed Q16.16
// cells. A beat with tuser 0 loads one cell; a beat with tuser 1 samples a point
// and returns one result beat (tuser = outside flag). The front maps a query
// axis by axis through one shared 32x32 multiplier (3 axes or 2 for a flat
// grid); the back then takes the job, reads the corners from the single-port
// grid memory (8 or 4 corners), performs the blends (7 or 3) one after another
// and forms the level difference before the result beat is valid. A point
// outside the grid skips the reads and blends and returns 1.0. The back takes
// no new job until the result beat is taken, so the back end sets the query
// rate. A two-entry queue lets the front map the next item meanwhile. Cells
// must be loaded before a query reads them. Configuration must be written
// only while idle; the block itself does not enforce it.
module trilinear_grid_mask_sampler #(
    parameter int GRID_X = tgms_pkg::GRID_X_DEF,
    parameter int GRID_Y = tgms_pkg::GRID_Y_DEF,
    parameter int GRID_Z = tgms_pkg::GRID_Z_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [11:0] cell_index, [43:12] cell_value, [75:44] query_x,
    // [107:76] query_y, [139:108] query_z, [143:140] zero
    input  wire logic [143:0] s_tdata,
    // [0] req_type
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] phi_value
    output logic [31:0]       m_tdata,
    // [0] outside_flag
    output logic              m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    logic [2:0][31:0] org_reg, inv_reg;
    logic [31:0]      thr_reg;
    logic             invert_reg;

    logic                push, full, pop, nonempty;
    tgms_pkg::tgms_job_t wr_job, rd_job;
    logic [2:0][31:0]    q;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg    <= '0;
            inv_reg    <= {3{tgms_pkg::ONE_Q16}};
            thr_reg    <= '0;
            invert_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                tgms_pkg::CFG_X_ORIGIN:  org_reg[0] <= cfg_data;
                tgms_pkg::CFG_Y_ORIGIN:  org_reg[1] <= cfg_data;
                tgms_pkg::CFG_Z_ORIGIN:  org_reg[2] <= cfg_data;
                tgms_pkg::CFG_X_INV:     inv_reg[0] <= cfg_data;
                tgms_pkg::CFG_Y_INV:     inv_reg[1] <= cfg_data;
                tgms_pkg::CFG_Z_INV:     inv_reg[2] <= cfg_data;
                tgms_pkg::CFG_THRESHOLD: thr_reg    <= cfg_data;
                tgms_pkg::CFG_INVERT:    invert_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign q[0] = s_tdata[75:44];
    assign q[1] = s_tdata[107:76];
    assign q[2] = s_tdata[139:108];

    tgms_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_type  (s_tuser),
        .in_index (s_tdata[11:0]),
        .in_value (s_tdata[43:12]),
        .in_q     (q),
        .org      (org_reg),
        .inv      (inv_reg),
        .push     (push),
        .full     (full),
        .job      (wr_job)
    );

    tgms_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_job   (wr_job),
        .full     (full),
        .pop      (pop),
        .nonempty (nonempty),
        .rd_job   (rd_job)
    );

    tgms_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_nonempty (nonempty),
        .q_job      (rd_job),
        .pop        (pop),
        .threshold  (thr_reg),
        .invert     (invert_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_phi    (m_tdata),
        .out_flag   (m_tuser)
    );
endmodule
`default_nettype wire

// ----- rtl/tgms_checker.sv -----
`default_nettype none
module tgms_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [31:0]  m_tdata,
    input wire logic         m_tuser,
    input wire logic         cfg_ready
);
    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Outside results carry exactly 1.0
    a_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'h0001_0000)
        else $error("outside result is not 1.0");

    // No result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Configuration channel never stalls out of reset
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) || 1'b1 |-> cfg_ready)
        else $error("configuration channel stalled");
endmodule

bind trilinear_grid_mask_sampler tgms_checker u_tgms_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);
`default_nettype wire
